@@ rtl/core/tvs_pkg.sv @@
`default_nettype none

package tvs_pkg;

	// kind of input item, carried on s_tuser
	typedef enum logic {
		MODE_WRITE = 1'b0,
		MODE_QUERY = 1'b1
	} mode_t;

	localparam int AXES    = 3;  // x, y, z
	localparam int CORNERS = 8;  // corner c = {cy, cx, cz}, also bank b = {z[0], y[0], x[0]}

endpackage

`default_nettype wire

@@ rtl/core/tvs_ram.sv @@
`default_nettype none

module tvs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/tvs_lerp.sv @@
`default_nettype none

// Linear blend of lane pairs: (lo*(one-f) + hi*f + rnd) >> SHIFT, floor shift.
// Three stages: difference, multiply, add and shift.
module tvs_lerp #(
	parameter int LANES  = 4,
	parameter int IN_W   = 16,
	parameter int FRAC_W = 8,
	parameter int SHIFT  = 0,
	parameter int SIDE_W = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [IN_W-1:0]                 lo [LANES],
	input  logic signed [IN_W-1:0]                 hi [LANES],
	input  logic [FRAC_W-1:0]                      frac,
	input  logic [SIDE_W-1:0]                      side_in,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [IN_W+FRAC_W+1-SHIFT:0]    res [LANES],
	output logic [SIDE_W-1:0]                      side_out
);

	localparam int SUM_W = IN_W + FRAC_W + 2;
	localparam logic signed [SUM_W-1:0] RND = (SUM_W'(1) << SHIFT) >> 1;

	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic signed [IN_W-1:0]  base_s1 [LANES];
	logic signed [IN_W:0]    diff_s1 [LANES];
	logic [FRAC_W-1:0]       frac_s1;
	logic [SIDE_W-1:0]       side_s1;

	logic signed [IN_W-1:0]  base_s2 [LANES];
	logic signed [SUM_W-1:0] prod_s2 [LANES];
	logic [SIDE_W-1:0]       side_s2;

	logic signed [SUM_W-1:0] sum [LANES];

	logic signed [SUM_W-SHIFT-1:0] res_s3 [LANES];
	logic [SIDE_W-1:0]             side_s3;

	assign rdy_s3   = !vld_s3 || out_ready;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			sum[l] = (SUM_W'(base_s2[l]) <<< FRAC_W) + prod_s2[l] + RND;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			for (int l = 0; l < LANES; l++) begin
				base_s1[l] <= lo[l];
				diff_s1[l] <= (IN_W+1)'(hi[l]) - (IN_W+1)'(lo[l]);
			end
			frac_s1 <= frac;
			side_s1 <= side_in;
		end
		if (rdy_s2) begin
			for (int l = 0; l < LANES; l++) begin
				base_s2[l] <= base_s1[l];
				prod_s2[l] <= diff_s1[l] * $signed({1'b0, frac_s1});
			end
			side_s2 <= side_s1;
		end
		if (rdy_s3) begin
			for (int l = 0; l < LANES; l++) begin
				res_s3[l] <= sum[l][SUM_W-1:SHIFT];
			end
			side_s3 <= side_s2;
		end
	end

	assign out_valid = vld_s3;
	assign res       = res_s3;
	assign side_out  = side_s3;

endmodule

`default_nettype wire

@@ rtl/core/tvs_volume.sv @@
`default_nettype none

// Volume split into eight banks by index parity; the two corners of an axis
// always differ in parity (or coincide), so each bank serves one corner.
module tvs_volume import tvs_pkg::*; #(
	parameter int AXIS_BITS   = 6,
	parameter int SAMPLE_BITS = 16,
	parameter int SIDE_W      = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  mode_t                         mode,
	input  logic [AXIS_BITS-1:0]          wr_x,
	input  logic [AXIS_BITS-1:0]          wr_y,
	input  logic [AXIS_BITS-1:0]          wr_z,
	input  logic signed [SAMPLE_BITS-1:0] wr_value,
	input  logic [AXIS_BITS-1:0]          lo [AXES],
	input  logic [AXIS_BITS-1:0]          hi [AXES],
	input  logic [SIDE_W-1:0]             side_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] corner [CORNERS],
	output logic [SIDE_W-1:0]             side_out
);

	localparam int HALF    = AXIS_BITS - 1;
	localparam int BANK_AW = (AXIS_BITS > 1) ? 3 * HALF : 1;
	localparam int FULL_W  = 3 * AXIS_BITS;

	function automatic logic [BANK_AW-1:0] bank_addr(
		input logic [AXIS_BITS-1:0] ix,
		input logic [AXIS_BITS-1:0] iy,
		input logic [AXIS_BITS-1:0] iz
	);
		logic [FULL_W-1:0] full;
		full = (FULL_W'(iz >> 1) << (2 * HALF)) | (FULL_W'(iy >> 1) << HALF) |
		       FULL_W'(ix >> 1);
		return full[BANK_AW-1:0];
	endfunction

	logic                   accept;
	logic                   rdy;
	logic [2:0]             wr_bank;
	logic [BANK_AW-1:0]     wr_addr;
	logic [SAMPLE_BITS-1:0] rdata [CORNERS];

	logic                   vld_s1;
	logic [AXES-1:0]        lo_par_s1;
	logic [AXES-1:0]        hi_par_s1;
	logic [SIDE_W-1:0]      side_s1;

	assign rdy      = !vld_s1 || out_ready;
	assign in_ready = rdy;
	assign accept   = in_valid && rdy;
	assign wr_bank  = {wr_z[0], wr_y[0], wr_x[0]};
	assign wr_addr  = bank_addr(wr_x, wr_y, wr_z);

	for (genvar b = 0; b < CORNERS; b++) begin : g_bank
		localparam int BX = b % 2;
		localparam int BY = (b / 2) % 2;
		localparam int BZ = b / 4;
		logic [AXIS_BITS-1:0] rx, ry, rz;
		logic                 we;

		// pick whichever corner of each axis lands in this bank
		assign rx = (lo[0][0] == 1'(BX)) ? lo[0] : hi[0];
		assign ry = (lo[1][0] == 1'(BY)) ? lo[1] : hi[1];
		assign rz = (lo[2][0] == 1'(BZ)) ? lo[2] : hi[2];
		assign we = accept && (mode == MODE_WRITE) && (wr_bank == 3'(b));

		tvs_ram #(
			.WIDTH (SAMPLE_BITS),
			.DEPTH (1 << BANK_AW)
		) u_bank (
			.clk   (clk),
			.we    (we),
			.waddr (wr_addr),
			.wdata (wr_value),
			.re    (rdy),
			.raddr (bank_addr(rx, ry, rz)),
			.rdata (rdata[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy) begin
			vld_s1 <= accept && (mode == MODE_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy) begin
			for (int k = 0; k < AXES; k++) begin
				lo_par_s1[k] <= lo[k][0];
				hi_par_s1[k] <= hi[k][0];
			end
			side_s1 <= side_in;
		end
	end

	for (genvar c = 0; c < CORNERS; c++) begin : g_corner
		localparam int CZ = c % 2;
		localparam int CX = (c / 2) % 2;
		localparam int CY = c / 4;
		logic [2:0] sel;

		assign sel = {(CZ != 0) ? hi_par_s1[2] : lo_par_s1[2],
		              (CY != 0) ? hi_par_s1[1] : lo_par_s1[1],
		              (CX != 0) ? hi_par_s1[0] : lo_par_s1[0]};
		assign corner[c] = $signed(rdata[sel]);
	end

	assign out_valid = vld_s1;
	assign side_out  = side_s1;

endmodule

`default_nettype wire

@@ rtl/core/trilinear_volume_sampler.sv @@
// Query path, s_tdata transfer to m_tvalid: 1 bank read stage, then 3 x 3 lerp stages.
// Throughput: one item per cycle unless m_tready stalls; each lerp stage is one multiply.
// Writes and queries mix; writes return nothing, and a query right after a write sees it.
// Reset (arst_n low, async): pipeline valid flags clear, size registers return to 64 voxels.
// Volume memory is not cleared; a voxel reads as garbage until written.
`default_nettype none

module trilinear_volume_sampler import tvs_pkg::*; #(
	parameter int AXIS_BITS   = 6,
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	// input stream
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// voxel_x, voxel_y, voxel_z, voxel_value, pos_x, pos_y, pos_z, zero pad
	input  logic [((3*AXIS_BITS+SAMPLE_BITS+3*(AXIS_BITS+FRAC_BITS)+7)/8)*8-1:0] s_tdata,
	// mode
	input  logic                                       s_tuser,
	// result stream
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// sample_out, zero pad
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]           m_tdata,
	// configuration writes
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [1:0]                                 cfg_index,
	input  logic [AXIS_BITS:0]                         cfg_data
);

	localparam int POS_W     = AXIS_BITS + FRAC_BITS;
	localparam int SIZE_W    = AXIS_BITS + 1;
	localparam int M_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int SB        = SAMPLE_BITS;
	localparam int FB        = FRAC_BITS;

	// s_tdata field offsets, lowest first
	localparam int OFF_VX  = 0;
	localparam int OFF_VY  = OFF_VX + AXIS_BITS;
	localparam int OFF_VZ  = OFF_VY + AXIS_BITS;
	localparam int OFF_VAL = OFF_VZ + AXIS_BITS;
	localparam int OFF_PX  = OFF_VAL + SAMPLE_BITS;
	localparam int OFF_PY  = OFF_PX + POS_W;
	localparam int OFF_PZ  = OFF_PY + POS_W;

	// register indexes on cfg_index
	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;

	localparam logic signed [SB+1:0] R_MAX = {3'b000, {(SB-1){1'b1}}};
	localparam logic signed [SB+1:0] R_MIN = {3'b111, {(SB-1){1'b0}}};

	// Size register value to last usable index. Zero acts as one voxel,
	// anything at or past the full axis means the whole axis.
	function automatic logic [AXIS_BITS-1:0] size_to_lim(input logic [SIZE_W-1:0] v);
		logic [AXIS_BITS-1:0] lim;
		if (v == '0) begin
			lim = '0;
		end else if (v[AXIS_BITS]) begin
			lim = '1;
		end else begin
			lim = AXIS_BITS'(v - 1'b1);
		end
		return lim;
	endfunction

	// ---------------------------------------------------------------
	// Configuration: keep last index per axis instead of the raw size
	// ---------------------------------------------------------------
	logic [AXIS_BITS-1:0] lim_q [AXES];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < AXES; k++) begin
				lim_q[k] <= '1;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SIZE_X: lim_q[0] <= size_to_lim(cfg_data);
				REG_SIZE_Y: lim_q[1] <= size_to_lim(cfg_data);
				REG_SIZE_Z: lim_q[2] <= size_to_lim(cfg_data);
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Input unpacking and corner index generation
	// ---------------------------------------------------------------
	mode_t                   mode;
	logic [AXIS_BITS-1:0]    voxel_x, voxel_y, voxel_z;
	logic signed [SB-1:0]    voxel_value;
	logic [POS_W-1:0]        pos    [AXES];
	logic [AXIS_BITS-1:0]    ip     [AXES];
	logic [AXIS_BITS-1:0]    lo_raw [AXES];
	logic [AXIS_BITS-1:0]    lo_idx [AXES];
	logic [AXIS_BITS-1:0]    hi_idx [AXES];
	logic [FB-1:0]           frac   [AXES];

	assign mode        = mode_t'(s_tuser);
	assign voxel_x     = s_tdata[OFF_VX +: AXIS_BITS];
	assign voxel_y     = s_tdata[OFF_VY +: AXIS_BITS];
	assign voxel_z     = s_tdata[OFF_VZ +: AXIS_BITS];
	assign voxel_value = $signed(s_tdata[OFF_VAL +: SB]);
	assign pos[0]      = s_tdata[OFF_PX +: POS_W];
	assign pos[1]      = s_tdata[OFF_PY +: POS_W];
	assign pos[2]      = s_tdata[OFF_PZ +: POS_W];

	// Positions are one-based: low corner is ip-1 (floored at voxel zero),
	// high corner is ip; both clamp to the last voxel in use.
	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			ip[k]     = pos[k][POS_W-1:FB];
			frac[k]   = pos[k][FB-1:0];
			lo_raw[k] = (ip[k] == '0) ? '0 : ip[k] - AXIS_BITS'(1);
			lo_idx[k] = (lo_raw[k] > lim_q[k]) ? lim_q[k] : lo_raw[k];
			hi_idx[k] = (ip[k] > lim_q[k]) ? lim_q[k] : ip[k];
		end
	end

	// ---------------------------------------------------------------
	// Banked volume: writes land at the transfer edge, queries read all
	// eight corners at once. Fractions ride along as side data.
	// ---------------------------------------------------------------
	logic                  vol_valid, vol_ready;
	logic signed [SB-1:0]  corner [CORNERS];
	logic [3*FB-1:0]       vol_side;

	tvs_volume #(
		.AXIS_BITS   (AXIS_BITS),
		.SAMPLE_BITS (SB),
		.SIDE_W      (3 * FB)
	) u_volume (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.mode      (mode),
		.wr_x      (voxel_x),
		.wr_y      (voxel_y),
		.wr_z      (voxel_z),
		.wr_value  (voxel_value),
		.lo        (lo_idx),
		.hi        (hi_idx),
		.side_in   ({frac[2], frac[1], frac[0]}),
		.out_valid (vol_valid),
		.out_ready (vol_ready),
		.corner    (corner),
		.side_out  (vol_side)
	);

	// ---------------------------------------------------------------
	// Blend along z: four lanes, lane l = {cy, cx}; exact, FB fraction bits
	// ---------------------------------------------------------------
	logic                   z_valid, z_ready;
	logic signed [SB-1:0]   z_lo  [CORNERS/2];
	logic signed [SB-1:0]   z_hi  [CORNERS/2];
	logic signed [SB+FB+1:0] z_res [CORNERS/2];
	logic [2*FB-1:0]        z_side;

	for (genvar l = 0; l < CORNERS/2; l++) begin : g_zlane
		assign z_lo[l] = corner[2*l];
		assign z_hi[l] = corner[2*l+1];
	end

	tvs_lerp #(
		.LANES  (CORNERS/2),
		.IN_W   (SB),
		.FRAC_W (FB),
		.SHIFT  (0),
		.SIDE_W (2 * FB)
	) u_lerp_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vol_valid),
		.in_ready  (vol_ready),
		.lo        (z_lo),
		.hi        (z_hi),
		.frac      (vol_side[2*FB +: FB]),
		.side_in   (vol_side[2*FB-1:0]),
		.out_valid (z_valid),
		.out_ready (z_ready),
		.res       (z_res),
		.side_out  (z_side)
	);

	// ---------------------------------------------------------------
	// Blend along x: two lanes (cy), rounded back to FB fraction bits.
	// A z blend stays within the sample range, so SB+FB bits hold it.
	// ---------------------------------------------------------------
	logic                    x_valid, x_ready;
	logic signed [SB+FB-1:0] x_lo  [2];
	logic signed [SB+FB-1:0] x_hi  [2];
	logic signed [SB+FB+1:0] x_res [2];
	logic [FB-1:0]           x_side;

	for (genvar m = 0; m < 2; m++) begin : g_xlane
		assign x_lo[m] = $signed(z_res[2*m][SB+FB-1:0]);
		assign x_hi[m] = $signed(z_res[2*m+1][SB+FB-1:0]);
	end

	tvs_lerp #(
		.LANES  (2),
		.IN_W   (SB + FB),
		.FRAC_W (FB),
		.SHIFT  (FB),
		.SIDE_W (FB)
	) u_lerp_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (z_valid),
		.in_ready  (z_ready),
		.lo        (x_lo),
		.hi        (x_hi),
		.frac      (z_side[FB-1:0]),
		.side_in   (z_side[2*FB-1:FB]),
		.out_valid (x_valid),
		.out_ready (x_ready),
		.res       (x_res),
		.side_out  (x_side)
	);

	// ---------------------------------------------------------------
	// Blend along y: one lane, rounded to an integer sample
	// ---------------------------------------------------------------
	logic signed [SB+FB-1:0] y_lo  [1];
	logic signed [SB+FB-1:0] y_hi  [1];
	logic signed [SB+1:0]    y_res [1];

	assign y_lo[0] = $signed(x_res[0][SB+FB-1:0]);
	assign y_hi[0] = $signed(x_res[1][SB+FB-1:0]);

	tvs_lerp #(
		.LANES  (1),
		.IN_W   (SB + FB),
		.FRAC_W (FB),
		.SHIFT  (2 * FB),
		.SIDE_W (1)
	) u_lerp_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (x_valid),
		.in_ready  (x_ready),
		.lo        (y_lo),
		.hi        (y_hi),
		.frac      (x_side),
		.side_in   (1'b0),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res       (y_res),
		.side_out  ()
	);

	// ---------------------------------------------------------------
	// Saturate to the sample range; the last lerp stage is the output register
	// ---------------------------------------------------------------
	logic [SB-1:0] sample_out;

	always_comb begin
		if (y_res[0] > R_MAX) begin
			sample_out = R_MAX[SB-1:0];
		end else if (y_res[0] < R_MIN) begin
			sample_out = R_MIN[SB-1:0];
		end else begin
			sample_out = y_res[0][SB-1:0];
		end
	end

	assign m_tdata = M_TDATA_W'(sample_out);

`ifndef SYNTH
	logic query_xfer;
	assign query_xfer = s_tvalid && s_tready && (mode == MODE_QUERY);

	// bank scheme needs the two corners of each axis equal or adjacent
	a_corner_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		query_xfer |->
			((hi_idx[0] == lo_idx[0]) || (hi_idx[0] == lo_idx[0] + 1'b1)) &&
			((hi_idx[1] == lo_idx[1]) || (hi_idx[1] == lo_idx[1] + 1'b1)) &&
			((hi_idx[2] == lo_idx[2]) || (hi_idx[2] == lo_idx[2] + 1'b1)))
		else $error("corner pair not adjacent");

	a_corner_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		query_xfer |->
			(hi_idx[0] <= lim_q[0]) && (hi_idx[1] <= lim_q[1]) && (hi_idx[2] <= lim_q[2]))
		else $error("corner index past configured size");

	a_size_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && (cfg_index == REG_SIZE_X) && (cfg_data == '0)) |=>
			(lim_q[0] == '0))
		else $error("size zero not treated as one voxel");

	a_size_big: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && (cfg_index == REG_SIZE_Y) && cfg_data[AXIS_BITS]) |=>
			(lim_q[1] == '1))
		else $error("oversize not clamped to full axis");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import tvs_pkg::*;

	localparam int AXIS_BITS   = 6;
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 8;
	localparam int POS_BITS    = AXIS_BITS + FRAC_BITS;
	localparam int TDATA_W     = ((3*AXIS_BITS + SAMPLE_BITS + 3*POS_BITS + 7) / 8) * 8;
	localparam int MDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int AXIS_LEN    = 1 << AXIS_BITS;
	localparam int POS_MAX     = (1 << POS_BITS) - 1;
	localparam int ONE         = 1 << FRAC_BITS;

	// configuration register indexes
	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;

	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 300;      // long output hold-off
	localparam int CYCLE_LIMIT  = 1000000;  // watchdog
	localparam int PRINT_CAP    = 50;

	typedef struct {
		mode_t                   mode;
		logic [AXIS_BITS-1:0]    vx, vy, vz;
		logic signed [SAMPLE_BITS-1:0] value;
		logic [POS_BITS-1:0]     px, py, pz;
	} vol_item_t;

	// ---------------------------------------------------------------- clock, reset, DUT
	logic clk = 1'b0;
	always #4 clk = ~clk;

	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [TDATA_W-1:0]     s_tdata;   // voxel_x, voxel_y, voxel_z, voxel_value, pos_x, pos_y, pos_z, pad
	logic                   s_tuser;   // mode
	logic                   m_tvalid;
	logic                   m_tready;
	logic [MDATA_W-1:0]     m_tdata;   // sample_out
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [1:0]             cfg_index;
	logic [AXIS_BITS:0]     cfg_data;

	trilinear_volume_sampler #(
		.AXIS_BITS  (AXIS_BITS),
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// ---------------------------------------------------------------- predictor state
	// Shadow of the voxel memory; only written entries exist, so a missing key
	// means the DUT would return garbage for it.
	logic signed [SAMPLE_BITS-1:0] volume_mem [int];
	logic [AXIS_BITS:0]            size_reg [3];
	logic signed [SAMPLE_BITS-1:0] pending_samples [$];

	int  mismatch_count = 0;
	int  cycle_count    = 0;
	bit  tx_idling      = 1'b1;
	bit  rx_idling      = 1'b1;
	bit  hold_req       = 1'b0;
	int  rx_run         = 0;

	// ---------------------------------------------------------------- helpers
	// Register value -> voxels actually in use (0 behaves as 1, >64 as 64).
	function automatic int span(input logic [AXIS_BITS:0] s);
		if (s == 0)
			return 1;
		if (s > AXIS_LEN)
			return AXIS_LEN;
		return int'(s);
	endfunction

	// Low corner sits at ip-1 (zero based), clamped at voxel zero and at the end.
	function automatic int axis_lo(input logic [POS_BITS-1:0] p, input int s);
		int ip;
		ip = p >> FRAC_BITS;
		ip = (ip == 0) ? 0 : ip - 1;
		return (ip >= s) ? s - 1 : ip;
	endfunction

	function automatic int axis_hi(input logic [POS_BITS-1:0] p, input int s);
		int ip;
		ip = p >> FRAC_BITS;
		return (ip >= s) ? s - 1 : ip;
	endfunction

	function automatic int voxel_addr(input int x, input int y, input int z);
		return (z << (2*AXIS_BITS)) | (y << AXIS_BITS) | x;
	endfunction

	function automatic longint voxel_at(input int x, input int y, input int z);
		int a;
		a = voxel_addr(x, y, z);
		if (!volume_mem.exists(a))
			return 0;
		return longint'(volume_mem[a]);
	endfunction

	// Blend z first, then x (round half up), then y, then saturate.
	function automatic logic signed [SAMPLE_BITS-1:0] interp_sample(input vol_item_t q);
		int     lo [3];
		int     hi [3];
		longint fx, fy, fz, r, smax, smin;
		longint acc [2][2];
		longint row [2];
		int     xx, yy;
		lo[0] = axis_lo(q.px, span(size_reg[REG_SIZE_X]));
		hi[0] = axis_hi(q.px, span(size_reg[REG_SIZE_X]));
		lo[1] = axis_lo(q.py, span(size_reg[REG_SIZE_Y]));
		hi[1] = axis_hi(q.py, span(size_reg[REG_SIZE_Y]));
		lo[2] = axis_lo(q.pz, span(size_reg[REG_SIZE_Z]));
		hi[2] = axis_hi(q.pz, span(size_reg[REG_SIZE_Z]));
		fx = q.px[FRAC_BITS-1:0];
		fy = q.py[FRAC_BITS-1:0];
		fz = q.pz[FRAC_BITS-1:0];
		for (int iy = 0; iy < 2; iy++) begin
			for (int ix = 0; ix < 2; ix++) begin
				yy = iy ? hi[1] : lo[1];
				xx = ix ? hi[0] : lo[0];
				acc[iy][ix] = voxel_at(xx, yy, lo[2]) * (ONE - fz) +
				              voxel_at(xx, yy, hi[2]) * fz;
			end
		end
		for (int i = 0; i < 2; i++)
			row[i] = (acc[i][0] * (ONE - fx) + acc[i][1] * fx + ONE / 2) >>> FRAC_BITS;
		r = (row[0] * (ONE - fy) + row[1] * fy + (longint'(1) << (2*FRAC_BITS - 1)))
		    >>> (2*FRAC_BITS);
		smax = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
		smin = -smax - 1;
		if (r > smax)
			r = smax;
		if (r < smin)
			r = smin;
		return r[SAMPLE_BITS-1:0];
	endfunction

	// Runs at the accepting edge: writes land before any later query.
	function automatic void model_accept(input vol_item_t it);
		if (it.mode == MODE_WRITE)
			volume_mem[voxel_addr(it.vx, it.vy, it.vz)] = it.value;
		else
			pending_samples.push_back(interp_sample(it));
	endfunction

	// Idle lengths: half none, most short, a few long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	// Spread positions over the used span: below one, on voxels, past the end.
	function automatic logic [POS_BITS-1:0] rand_pos(input int s);
		int p;
		case ($urandom_range(0, 9))
			0, 1: p = $urandom_range(0, POS_MAX);
			2, 3: p = $urandom_range(0, s) << FRAC_BITS;
			default: p = $urandom_range(0, (s + 1) * ONE - 1);
		endcase
		return POS_BITS'((p > POS_MAX) ? POS_MAX : p);
	endfunction

	// Unused fields of each kind carry random bits; the DUT must ignore them.
	function automatic vol_item_t make_write(input int x, input int y, input int z,
	                                         input logic signed [SAMPLE_BITS-1:0] v);
		vol_item_t it;
		it.mode  = MODE_WRITE;
		it.vx    = AXIS_BITS'(x);
		it.vy    = AXIS_BITS'(y);
		it.vz    = AXIS_BITS'(z);
		it.value = v;
		it.px    = POS_BITS'($urandom());
		it.py    = POS_BITS'($urandom());
		it.pz    = POS_BITS'($urandom());
		return it;
	endfunction

	function automatic vol_item_t make_query(input int px, input int py, input int pz);
		vol_item_t it;
		it.mode  = MODE_QUERY;
		it.vx    = AXIS_BITS'($urandom());
		it.vy    = AXIS_BITS'($urandom());
		it.vz    = AXIS_BITS'($urandom());
		it.value = SAMPLE_BITS'($urandom());
		it.px    = POS_BITS'(px);
		it.py    = POS_BITS'(py);
		it.pz    = POS_BITS'(pz);
		return it;
	endfunction

	// ---------------------------------------------------------------- mismatch reporting
	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch @%0d: %s", cycle_count, what);
	endtask

	// ---------------------------------------------------------------- input side
	// Called at a falling edge, returns at a falling edge. valid stays high
	// across back-to-back transfers; it is only lowered for a gap.
	task automatic send_item(input vol_item_t it);
		int gap;
		s_tdata  <= {{(TDATA_W - 3*AXIS_BITS - SAMPLE_BITS - 3*POS_BITS){1'b0}},
		             it.pz, it.py, it.px, it.value, it.vz, it.vy, it.vx};
		s_tuser  <= it.mode;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		model_accept(it);
		@(negedge clk);
		gap = tx_idling ? gap_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Write any corner of q that was never written, so no read hits garbage.
	task automatic fill_corners(input vol_item_t q);
		int lx, hx, ly, hy, lz, hz, x, y, z;
		lx = axis_lo(q.px, span(size_reg[REG_SIZE_X]));
		hx = axis_hi(q.px, span(size_reg[REG_SIZE_X]));
		ly = axis_lo(q.py, span(size_reg[REG_SIZE_Y]));
		hy = axis_hi(q.py, span(size_reg[REG_SIZE_Y]));
		lz = axis_lo(q.pz, span(size_reg[REG_SIZE_Z]));
		hz = axis_hi(q.pz, span(size_reg[REG_SIZE_Z]));
		for (int c = 0; c < 8; c++) begin
			x = c[0] ? hx : lx;
			y = c[1] ? hy : ly;
			z = c[2] ? hz : lz;
			if (!volume_mem.exists(voxel_addr(x, y, z)))
				send_item(make_write(x, y, z, rand_value()));
		end
	endtask

	task automatic send_query(input int px, input int py, input int pz);
		vol_item_t q;
		q = make_query(px, py, pz);
		fill_corners(q);
		send_item(q);
	endtask

	// Mostly queries; writes land inside the used box or anywhere.
	task automatic send_random_item();
		int sx, sy, sz;
		sx = span(size_reg[REG_SIZE_X]);
		sy = span(size_reg[REG_SIZE_Y]);
		sz = span(size_reg[REG_SIZE_Z]);
		if ($urandom_range(0, 9) < 6)
			send_query(rand_pos(sx), rand_pos(sy), rand_pos(sz));
		else if ($urandom_range(0, 9) < 7)
			send_item(make_write($urandom_range(0, sx - 1), $urandom_range(0, sy - 1),
			                     $urandom_range(0, sz - 1), rand_value()));
		else
			send_item(make_write($urandom(), $urandom(), $urandom(), rand_value()));
	endtask

	// Sender stops and waits until every expected sample is back, then lets
	// the pipeline empty of trailing writes.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Only called with the DUT idle.
	task automatic write_size(input logic [1:0] idx, input logic [AXIS_BITS:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		size_reg[idx] = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_sizes(input logic [AXIS_BITS:0] sx, input logic [AXIS_BITS:0] sy,
	                         input logic [AXIS_BITS:0] sz);
		wait_drained();
		write_size(REG_SIZE_X, sx);
		write_size(REG_SIZE_Y, sy);
		write_size(REG_SIZE_Z, sz);
	endtask

	function automatic logic [AXIS_BITS:0] rand_size();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return (AXIS_BITS+1)'($urandom_range(AXIS_LEN + 1, 2*AXIS_LEN - 1));
			2: return (AXIS_BITS+1)'(AXIS_LEN);
			default: return (AXIS_BITS+1)'($urandom_range(1, 8));
		endcase
	endfunction

	// ---------------------------------------------------------------- output side
	// Receiver: random ready pattern, or a long hold-off when asked.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				m_tready <= 1'b1;
				rx_run = $urandom_range(0, 15);
			end else if (rx_run > 0) begin
				rx_run--;
			end else if (m_tready && rx_idling) begin
				rx_run = gap_len();
				if (rx_run > 0) begin
					m_tready <= 1'b0;
					rx_run--;
				end else begin
					rx_run = $urandom_range(0, 15);
				end
			end else begin
				m_tready <= 1'b1;
				rx_run = $urandom_range(0, 15);
			end
		end
	end

	// Each sample transfer is checked against the oldest expectation.
	always @(posedge clk) begin : sample_check
		logic signed [SAMPLE_BITS-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_samples.size() == 0) begin
				report_mismatch($sformatf("unexpected sample_out %0d",
				                          $signed(m_tdata[SAMPLE_BITS-1:0])));
			end else begin
				want = pending_samples.pop_front();
				if (m_tdata[SAMPLE_BITS-1:0] !== want)
					report_mismatch($sformatf("sample_out got %0d want %0d",
					                          $signed(m_tdata[SAMPLE_BITS-1:0]), want));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests
	// Field extremes, exact voxel hits, fractions at 0, half and max, the
	// below-one clamp, a write followed at once by a query that reads it.
	task automatic test_directed_points();
		vol_item_t q;
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		send_item(make_write(0, 0, 0, 16'sh7fff));
		send_item(make_write(AXIS_LEN - 1, AXIS_LEN - 1, AXIS_LEN - 1, 16'sh8000));
		send_query(ONE, ONE, ONE);                 // lands exactly on voxel 0
		send_query(0, 0, 0);                       // below one: both corners voxel 0
		send_query(ONE - 1, ONE - 1, ONE - 1);     // max fraction, still below one
		send_query(POS_MAX, POS_MAX, POS_MAX);     // top of the field range
		send_query(POS_MAX & ~(ONE - 1), POS_MAX, 0);
		send_query(ONE + ONE / 2, ONE + ONE / 2, ONE + ONE / 2);  // half fraction
		// mixed full-scale corners around (10..11)
		for (int c = 0; c < 8; c++)
			send_item(make_write(10 + c[0], 10 + c[1], 10 + c[2],
			                     (c % 3 == 0) ? 16'sh7fff : 16'sh8000));
		send_query(11*ONE + 1, 11*ONE + ONE/2, 11*ONE + ONE - 1);
		send_query(11*ONE + ONE/2, 11*ONE + 3, 11*ONE + ONE/2);
		// query straight after a write to one of its corners
		q = make_query(6*ONE + 77, 6*ONE + 200, 6*ONE + 13);
		fill_corners(q);
		send_item(make_write(5, 5, 5, -16'sd1234));
		send_item(q);
		send_item(make_write(6, 5, 6, 16'sd31000));
		send_item(q);
		tx_idling = 1'b1;
		rx_idling = 1'b1;
	endtask

	// Every register, its extremes and its out-of-range encodings.
	task automatic test_size_registers();
		set_sizes(1, 1, 1);
		send_query(0, 0, 0);
		send_query(POS_MAX, POS_MAX, POS_MAX);
		send_query(2*ONE + 9, ONE + 100, 5*ONE);
		set_sizes(0, 0, 0);                        // zero behaves as one
		send_query(POS_MAX, 3*ONE + 1, ONE / 2);
		send_query(ONE, ONE, ONE);
		set_sizes(2*AXIS_LEN - 1, AXIS_LEN + 1, AXIS_LEN);  // above range behaves as 64
		send_query(POS_MAX, POS_MAX, POS_MAX);
		send_query(40*ONE + 5, 63*ONE + 250, 20*ONE);
		set_sizes(2, 3, 5);                        // past the end clamps to size-1
		send_query(3*ONE + 128, 4*ONE, 6*ONE + 255);
		send_query(2*ONE + 1, 3*ONE + 1, 5*ONE + 1);
		// one long axis at a time
		set_sizes(AXIS_LEN, 1, 1);
		repeat (20) send_random_item();
		set_sizes(1, AXIS_LEN, 1);
		repeat (20) send_random_item();
		set_sizes(1, 1, AXIS_LEN);
		repeat (20) send_random_item();
	endtask

	// Random phases, each under its own size setting.
	task automatic test_random_mix();
		for (int ph = 0; ph < 9; ph++) begin
			set_sizes(rand_size(), rand_size(), rand_size());
			repeat (40) send_random_item();
		end
	endtask

	// Receiver stops for a long stretch while queries keep coming, so the
	// pipeline fills and s_tready has to drop.
	task automatic test_output_backpressure();
		set_sizes(4, 4, 4);
		tx_idling = 1'b0;
		hold_req  = 1'b1;
		repeat (60) send_query(rand_pos(4), rand_pos(4), rand_pos(4));
		tx_idling = 1'b1;
		wait_drained();
	endtask

	// Sender pauses mid-stream until all samples are back, then resumes.
	task automatic test_drain_pause();
		set_sizes(6, 3, 7);
		repeat (30) send_random_item();
		wait_drained();
		repeat (30) send_random_item();
	endtask

	// Full rate on both sides.
	task automatic test_no_idling();
		set_sizes(8, 8, 8);
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		repeat (80) send_random_item();
		tx_idling = 1'b1;
		rx_idling = 1'b1;
	endtask

	// ---------------------------------------------------------------- sequence
	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = MODE_WRITE;
		cfg_valid = 1'b0;
		cfg_index = REG_SIZE_X;
		cfg_data  = '0;
		size_reg[REG_SIZE_X] = (AXIS_BITS+1)'(AXIS_LEN);
		size_reg[REG_SIZE_Y] = (AXIS_BITS+1)'(AXIS_LEN);
		size_reg[REG_SIZE_Z] = (AXIS_BITS+1)'(AXIS_LEN);
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_points();
		test_size_registers();
		test_random_mix();
		test_output_backpressure();
		test_drain_pause();
		test_no_idling();
		wait_drained();

		if (mismatch_count == 0 && pending_samples.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/tvs_pkg.sv
rtl/core/tvs_ram.sv
rtl/core/tvs_lerp.sv
rtl/core/tvs_volume.sv
rtl/core/trilinear_volume_sampler.sv
tb/tb_top.sv
